// ===== src/bhsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bhsp_pkg
// Types and codes shared by the binary header stream parser modules.
// ----------------------------------------------------------------------------
package bhsp_pkg;

    typedef enum logic [3:0] {
        PH_VERSION    = 4'd0,
        PH_METHOD     = 4'd1,
        PH_STAT_LO    = 4'd2,
        PH_STAT_HI    = 4'd3,
        PH_URI        = 4'd4,
        PH_PFX_FIRST  = 4'd5,
        PH_PFX_SECOND = 4'd6,
        PH_BODY       = 4'd7,
        PH_PAYLOAD    = 4'd8,
        PH_ERROR      = 4'd9
    } t_phase;

    typedef enum logic [3:0] {
        TK_VERSION   = 4'd0,
        TK_METHOD    = 4'd1,
        TK_STAT_LO   = 4'd2,
        TK_STAT_HI   = 4'd3,
        TK_URI       = 4'd4,
        TK_URI_END   = 4'd5,
        TK_NAME_PFX  = 4'd6,
        TK_NAME      = 4'd7,
        TK_VALUE_PFX = 4'd8,
        TK_VALUE     = 4'd9,
        TK_HDR_END   = 4'd10,
        TK_PAYLOAD   = 4'd11,
        TK_ERROR     = 4'd12
    } t_token;

    localparam int unsigned LEN_W = 15;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_message;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       byte_out;
        t_token           token_kind;
        logic [LEN_W-1:0] decoded_length;
        logic             length_valid;
        logic [7:0]       field_index;
        logic             header_done;
        logic             error_flag;
    } t_out_item;

    typedef struct packed {
        t_phase           phase;
        logic [LEN_W-1:0] remaining;
        logic [7:0]       prefix_low;
        logic             in_value;
        logic [7:0]       field_cnt;
    } t_parse_state;

endpackage

// ===== src/bhsp_intf.sv =====
// ----------------------------------------------------------------------------
// bhsp interfaces
// Valid/ready channels for message bytes, tagged results and configuration.
// ----------------------------------------------------------------------------
interface bhsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_message;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output start_of_message,
                    output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input start_of_message,
                    input end_of_buffer, output ready);
endinterface

interface bhsp_out_if;
    logic                       valid;
    logic                       ready;
    logic [7:0]                 byte_out;
    logic [3:0]                 token_kind;
    logic [bhsp_pkg::LEN_W-1:0] decoded_length;
    logic                       length_valid;
    logic [7:0]                 field_index;
    logic                       header_done;
    logic                       error_flag;

    modport source (output valid, output byte_out, output token_kind,
                    output decoded_length, output length_valid, output field_index,
                    output header_done, output error_flag, input ready);
    modport sink   (input valid, input byte_out, input token_kind,
                    input decoded_length, input length_valid, input field_index,
                    input header_done, input error_flag, output ready);
endinterface

interface bhsp_cfg_if;
    logic valid;
    logic ready;
    logic message_kind;

    modport source (output valid, output message_kind, input ready);
    modport sink   (input valid, input message_kind, output ready);
endinterface

// ===== src/bhsp_in_stage.sv =====
// ----------------------------------------------------------------------------
// bhsp_in_stage
// Input register: captures one byte transfer and holds it until consumed.
// ----------------------------------------------------------------------------
module bhsp_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bhsp_in_if.sink            i_byte,
    input  logic               i_advance,
    output logic               o_valid,
    output bhsp_pkg::t_in_item o_item
);

    logic               r_valid;
    bhsp_pkg::t_in_item r_item;
    logic               w_take;

    assign i_byte.ready = !r_valid || i_advance;
    assign w_take       = i_byte.valid && i_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.data_byte        <= i_byte.data_byte;
            r_item.start_of_message <= i_byte.start_of_message;
            r_item.end_of_buffer    <= i_byte.end_of_buffer;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== src/bhsp_decode.sv =====
// ----------------------------------------------------------------------------
// bhsp_decode
// Phase machine: tags one byte per step, decodes part lengths, counts fields.
// ----------------------------------------------------------------------------
module bhsp_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_kind,
    input  logic                i_step,
    input  bhsp_pkg::t_in_item  i_item,
    output bhsp_pkg::t_out_item o_result
);

    logic                   r_kind;
    bhsp_pkg::t_parse_state r_state;
    bhsp_pkg::t_parse_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= 1'b0;
        end else if (i_cfg_we) begin
            r_kind <= i_cfg_kind;
        end
    end

    always_comb begin
        bhsp_pkg::t_parse_state w;
        bhsp_pkg::t_out_item    res;
        logic [bhsp_pkg::LEN_W-1:0] len;
        logic [bhsp_pkg::LEN_W-1:0] rem_dec;
        logic                   pfx_done;
        logic                   part_done;

        w         = r_state;
        len       = '0;
        rem_dec   = '0;
        pfx_done  = 1'b0;
        part_done = 1'b0;

        if (i_item.start_of_message) begin
            w.phase      = bhsp_pkg::PH_VERSION;
            w.remaining  = '0;
            w.prefix_low = '0;
            w.in_value   = 1'b0;
            w.field_cnt  = '0;
        end

        res.byte_out       = i_item.data_byte;
        res.token_kind     = bhsp_pkg::TK_ERROR;
        res.decoded_length = '0;
        res.length_valid   = 1'b0;
        res.field_index    = w.field_cnt;
        res.header_done    = 1'b0;
        res.error_flag     = 1'b0;

        unique case (w.phase)
            bhsp_pkg::PH_VERSION: begin
                res.token_kind = bhsp_pkg::TK_VERSION;
                w.phase = r_kind ? bhsp_pkg::PH_STAT_LO : bhsp_pkg::PH_METHOD;
            end
            bhsp_pkg::PH_METHOD: begin
                res.token_kind = bhsp_pkg::TK_METHOD;
                w.phase = bhsp_pkg::PH_URI;
            end
            bhsp_pkg::PH_STAT_LO: begin
                res.token_kind = bhsp_pkg::TK_STAT_LO;
                w.phase = bhsp_pkg::PH_STAT_HI;
            end
            bhsp_pkg::PH_STAT_HI: begin
                res.token_kind = bhsp_pkg::TK_STAT_HI;
                w.phase = bhsp_pkg::PH_PFX_FIRST;
            end
            bhsp_pkg::PH_URI: begin
                if (i_item.data_byte == 8'd0) begin
                    res.token_kind = bhsp_pkg::TK_URI_END;
                    w.phase = bhsp_pkg::PH_PFX_FIRST;
                end else begin
                    res.token_kind = bhsp_pkg::TK_URI;
                end
            end
            bhsp_pkg::PH_PFX_FIRST: begin
                if (!w.in_value && i_item.data_byte == 8'd0) begin
                    res.token_kind  = bhsp_pkg::TK_HDR_END;
                    res.header_done = 1'b1;
                    w.phase = bhsp_pkg::PH_PAYLOAD;
                end else begin
                    res.token_kind = w.in_value ? bhsp_pkg::TK_VALUE_PFX
                                                : bhsp_pkg::TK_NAME_PFX;
                    if (i_item.data_byte[0]) begin
                        w.prefix_low = i_item.data_byte;
                        w.phase = bhsp_pkg::PH_PFX_SECOND;
                    end else begin
                        len = {8'd0, i_item.data_byte[7:1]};
                        pfx_done = 1'b1;
                    end
                end
            end
            bhsp_pkg::PH_PFX_SECOND: begin
                res.token_kind = w.in_value ? bhsp_pkg::TK_VALUE_PFX
                                            : bhsp_pkg::TK_NAME_PFX;
                len = {i_item.data_byte, w.prefix_low[7:1]};
                pfx_done = 1'b1;
            end
            bhsp_pkg::PH_BODY: begin
                res.token_kind = w.in_value ? bhsp_pkg::TK_VALUE : bhsp_pkg::TK_NAME;
                rem_dec = (w.remaining != '0) ? w.remaining - 1'b1 : w.remaining;
                w.remaining = rem_dec;
                part_done = (rem_dec == '0);
            end
            bhsp_pkg::PH_PAYLOAD: begin
                res.token_kind = bhsp_pkg::TK_PAYLOAD;
            end
            default: begin
                res.token_kind = bhsp_pkg::TK_ERROR;
                res.error_flag = 1'b1;
                w.phase = bhsp_pkg::PH_ERROR;
            end
        endcase

        if (pfx_done) begin
            res.decoded_length = len;
            res.length_valid   = 1'b1;
            w.remaining        = len;
            if (len != '0) begin
                w.phase = bhsp_pkg::PH_BODY;
            end else begin
                part_done = 1'b1;
            end
        end

        if (part_done) begin
            if (!w.in_value) begin
                w.in_value = 1'b1;
            end else begin
                w.in_value = 1'b0;
                if (w.field_cnt != 8'hFF) begin
                    w.field_cnt = w.field_cnt + 8'd1;
                end
            end
            w.phase = bhsp_pkg::PH_PFX_FIRST;
        end

        if (i_item.end_of_buffer && w.phase != bhsp_pkg::PH_PAYLOAD) begin
            w.phase = bhsp_pkg::PH_ERROR;
        end
        if (w.phase == bhsp_pkg::PH_ERROR) begin
            res.token_kind     = bhsp_pkg::TK_ERROR;
            res.error_flag     = 1'b1;
            res.decoded_length = '0;
            res.length_valid   = 1'b0;
            res.header_done    = 1'b0;
        end

        n_state  = w;
        o_result = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= bhsp_pkg::PH_VERSION;
            r_state.remaining  <= '0;
            r_state.prefix_low <= '0;
            r_state.in_value   <= 1'b0;
            r_state.field_cnt  <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_err_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.error_flag |=> r_state.phase == bhsp_pkg::PH_ERROR)
        else $error("error result without error phase");

    a_hdr_to_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.header_done |=> r_state.phase == bhsp_pkg::PH_PAYLOAD)
        else $error("header end without payload phase");

    a_fcnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_item.start_of_message |=> r_state.field_cnt >= $past(r_state.field_cnt))
        else $error("field count decreased within a message");

    a_len_on_pfx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.length_valid |->
            (o_result.token_kind == bhsp_pkg::TK_NAME_PFX ||
             o_result.token_kind == bhsp_pkg::TK_VALUE_PFX))
        else $error("length reported off a prefix byte");
`endif

endmodule

// ===== src/bhsp_out_stage.sv =====
// ----------------------------------------------------------------------------
// bhsp_out_stage
// Result register: holds one tagged byte until the downstream transfer.
// ----------------------------------------------------------------------------
module bhsp_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  bhsp_pkg::t_out_item i_item,
    output logic                o_free,
    bhsp_out_if.source          o_token
);

    logic                r_valid;
    bhsp_pkg::t_out_item r_item;

    assign o_free = !r_valid || o_token.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_token.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_token.valid          = r_valid;
    assign o_token.byte_out       = r_item.byte_out;
    assign o_token.token_kind     = r_item.token_kind;
    assign o_token.decoded_length = r_item.decoded_length;
    assign o_token.length_valid   = r_item.length_valid;
    assign o_token.field_index    = r_item.field_index;
    assign o_token.header_done    = r_item.header_done;
    assign o_token.error_flag     = r_item.error_flag;

endmodule

// ===== src/binary_header_stream_parser.sv =====
// ----------------------------------------------------------------------------
// binary_header_stream_parser
// Tags each message byte with its header part, decoded lengths and field index.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the result side is free and returns one
// tagged result per byte, in order. A byte transfer lands in the input
// register; when the result register is free, the phase machine updates
// its state and writes the tag into the result register, from which the
// result is offered. Both registers advance together while the result side
// drains, and the sustained rate is then one byte per cycle.
// Write message_kind only while no byte is in flight; it is sampled on the
// version byte.
module binary_header_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bhsp_in_if.sink     i_byte,
    bhsp_cfg_if.sink    i_cfg,
    bhsp_out_if.source  o_token
);

    logic                w_in_valid;
    bhsp_pkg::t_in_item  w_in_item;
    logic                w_out_free;
    logic                w_step;
    bhsp_pkg::t_out_item w_result;

    assign i_cfg.ready = 1'b1;
    assign w_step      = w_in_valid && w_out_free;

    bhsp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_advance (w_out_free),
        .o_valid   (w_in_valid),
        .o_item    (w_in_item)
    );

    bhsp_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_kind (i_cfg.message_kind),
        .i_step     (w_step),
        .i_item     (w_in_item),
        .o_result   (w_result)
    );

    bhsp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step),
        .i_item  (w_result),
        .o_free  (w_out_free),
        .o_token (o_token)
    );

endmodule
